/* src/keyed_slot_table_macros.svh */
// Assertion macros shared by the keyed slot table RTL.
`ifndef KEYED_SLOT_TABLE_MACROS_SVH
`define KEYED_SLOT_TABLE_MACROS_SVH

`ifndef SYNTH
// Property checked at every rising clock edge, switched off while reset is asserted.
`define KST_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);
// Condition that must be followed by a consequence in the next cycle.
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define KST_ASSERT(label, clk, rst_n, prop, msg)
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/kst_pkg.sv */
// Types, codes and defaults shared by the keyed slot table modules.
package kst_pkg;

	localparam int SLOTS_DEF = 512;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_FIND   = 2'd1;
	localparam logic [1:0] CMD_MOVE   = 2'd2;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_INVALID   = 3'd1;
	localparam logic [2:0] STAT_DUPLICATE = 3'd2;
	localparam logic [2:0] STAT_FULL      = 3'd3;
	localparam logic [2:0] STAT_NOTFOUND  = 3'd4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [14:0] batch_id;
		logic [15:0] quantity;
		logic [1:0]  kind;
		logic [8:0]  target_slot;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [8:0]  slot_index;
		logic [14:0] found_id;
		logic [15:0] found_quantity;
		logic [1:0]  found_kind;
		logic [9:0]  occupied_count;
	} rsp_t;

	// One slot as held in the table memory.
	typedef struct packed {
		logic        used;
		logic [14:0] key;
		logic [15:0] qty;
		logic [1:0]  kind;
	} entry_t;

endpackage

/* src/kst_slot_mem.sv */
// Slot memory of the keyed slot table: one write port, one registered read port.
module kst_slot_mem #(
	parameter int SLOTS = kst_pkg::SLOTS_DEF,
	localparam int IW = $clog2(SLOTS)
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [IW-1:0]   wr_addr,
	input  kst_pkg::entry_t wr_data,
	input  logic            rd_en,
	input  logic [IW-1:0]   rd_addr,
	output kst_pkg::entry_t rd_data
);

	kst_pkg::entry_t mem_q [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* src/keyed_slot_table.sv */
// Keyed slot table top level: command sequencer around the slot memory.
//
// The table holds SLOTS slots, each with an occupied mark, a 15-bit key, a
// 16-bit quantity and a 2-bit kind, all in one synchronous memory. Every
// command (insert, find, move) sweeps the whole memory, one slot per cycle
// through its single read port, looking for the lowest free slot, the slot
// holding the key and the contents of the move target in the same pass.
// A successful move writes two slots. The next request is taken once the
// response has been handed to the output register, even while that
// response still waits for the consumer. After reset the block clears
// the memory, one slot per cycle, and holds req_ready low until that pass
// is done. Apart from that clearing pass, the table is only written after
// a sweep has finished, so no read can overlap a write to the same slot.
// A move target at or beyond SLOTS is reported as invalid when the key
// is found.
`include "keyed_slot_table_macros.svh"

module keyed_slot_table #(
	parameter int SLOTS = kst_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  kst_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output kst_pkg::rsp_t rsp
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_DECIDE,
		S_MOVE2,
		S_RESP
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   addr_q;
	logic            rd_vld_s1;
	logic [IW-1:0]   addr_s1;
	logic            free_hit_q;
	logic            match_hit_q;
	logic [IW-1:0]   free_idx_q;
	logic [IW-1:0]   match_idx_q;
	kst_pkg::entry_t match_ent_q;
	kst_pkg::entry_t tgt_ent_q;
	logic [CW-1:0]   count_q;
	kst_pkg::req_t   req_q;
	kst_pkg::rsp_t   res_q;
	kst_pkg::rsp_t   rsp_q;
	logic            rsp_valid_q;

	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	kst_pkg::entry_t wr_data;
	logic            rd_en;
	kst_pkg::entry_t rd_data;

	logic            last_addr;
	logic            tgt_in_range;
	logic [IW-1:0]   tgt_idx;
	logic            ins_ok;
	logic            ins_commit;
	logic [CW-1:0]   count_inc;
	logic            mv_ok;
	logic            rsp_load;
	kst_pkg::rsp_t   res_d;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign last_addr    = (addr_q == IW'(SLOTS - 1));
	assign tgt_in_range = (int'(req_q.target_slot) < SLOTS);
	assign tgt_idx      = IW'(req_q.target_slot);
	assign rd_en        = (state_q == S_SCAN);
	assign rsp_load     = (state_q == S_RESP) && (!rsp_valid_q || rsp_ready);
	assign count_inc    = count_q + CW'(1);

	// Outcome of the sweep; a zero key never raises a match.
	assign ins_ok = (req_q.cmd == kst_pkg::CMD_INSERT) && free_hit_q &&
		(req_q.batch_id != '0) && !match_hit_q;
	assign ins_commit = (state_q == S_DECIDE) && ins_ok;
	assign mv_ok  = (req_q.cmd == kst_pkg::CMD_MOVE) && match_hit_q && tgt_in_range;

	kst_slot_mem #(
		.SLOTS(SLOTS)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(addr_q),
		.rd_data(rd_data)
	);

	// Write port. The clearing pass zeroes each slot; insert writes the free
	// slot; a move writes the target first and the source slot in the
	// following cycle. On an occupied target the two slots swap their contents, and a
	// move onto its own slot simply rewrites the same entry twice.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_DECIDE: begin
				if (ins_ok) begin
					wr_en   = 1'b1;
					wr_addr = free_idx_q;
					wr_data = '{used: 1'b1, key: req_q.batch_id,
						qty: req_q.quantity, kind: req_q.kind};
				end else if (mv_ok) begin
					wr_en        = 1'b1;
					wr_addr      = tgt_idx;
					wr_data      = match_ent_q;
					wr_data.used = 1'b1;
				end
			end
			S_MOVE2: begin
				wr_en   = 1'b1;
				wr_addr = match_idx_q;
				if (tgt_ent_q.used) begin
					wr_data = tgt_ent_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Response of the command, formed once the sweep is complete.
	always_comb begin
		res_d = '0;
		res_d.status = kst_pkg::STAT_INVALID;
		res_d.occupied_count = 10'(count_q);
		unique case (req_q.cmd)
			kst_pkg::CMD_INSERT: begin
				priority if (!free_hit_q) begin
					res_d.status = kst_pkg::STAT_FULL;
				end else if (req_q.batch_id == '0) begin
					res_d.status = kst_pkg::STAT_INVALID;
				end else if (match_hit_q) begin
					res_d.status = kst_pkg::STAT_DUPLICATE;
				end else begin
					res_d.status         = kst_pkg::STAT_OK;
					res_d.slot_index     = 9'(free_idx_q);
					res_d.occupied_count = 10'(count_inc);
				end
			end
			kst_pkg::CMD_FIND: begin
				if (match_hit_q) begin
					res_d.status         = kst_pkg::STAT_OK;
					res_d.slot_index     = 9'(match_idx_q);
					res_d.found_id       = match_ent_q.key;
					res_d.found_quantity = match_ent_q.qty;
					res_d.found_kind     = match_ent_q.kind;
				end else begin
					res_d.status = kst_pkg::STAT_NOTFOUND;
				end
			end
			kst_pkg::CMD_MOVE: begin
				priority if (!match_hit_q) begin
					res_d.status = kst_pkg::STAT_NOTFOUND;
				end else if (!tgt_in_range) begin
					res_d.status = kst_pkg::STAT_INVALID;
				end else begin
					res_d.status = kst_pkg::STAT_OK;
				end
			end
			default: begin
				res_d.status = kst_pkg::STAT_INVALID;
			end
		endcase
	end

	// Sequencer: state, sweep address, hit flags, occupancy and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			rd_vld_s1   <= 1'b0;
			free_hit_q  <= 1'b0;
			match_hit_q <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			// A new response may replace the one leaving in the same cycle.
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			// Read data of the previous sweep cycle is examined here.
			if (rd_vld_s1) begin
				if (!rd_data.used) begin
					free_hit_q <= 1'b1;
				end
				if (rd_data.used && (rd_data.key == req_q.batch_id) &&
					(req_q.batch_id != '0)) begin
					match_hit_q <= 1'b1;
				end
			end
			unique case (state_q)
				S_CLEAR: begin
					if (last_addr) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + IW'(1);
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						addr_q      <= '0;
						free_hit_q  <= 1'b0;
						match_hit_q <= 1'b0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (last_addr) begin
						addr_q  <= '0;
						state_q <= S_LAST;
					end else begin
						addr_q <= addr_q + IW'(1);
					end
				end
				S_LAST: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (ins_ok) begin
						count_q <= count_inc;
					end
					state_q <= mv_ok ? S_MOVE2 : S_RESP;
				end
				S_MOVE2: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request, sweep captures, pending and output responses.
	always_ff @(posedge clk) begin
		addr_s1 <= addr_q;
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (rd_vld_s1) begin
			if (!rd_data.used && !free_hit_q) begin
				free_idx_q <= addr_s1;
			end
			if (rd_data.used && (rd_data.key == req_q.batch_id) &&
				(req_q.batch_id != '0) && !match_hit_q) begin
				match_idx_q <= addr_s1;
				match_ent_q <= rd_data;
			end
			if (addr_s1 == tgt_idx) begin
				tgt_ent_q <= rd_data;
			end
		end
		if (state_q == S_DECIDE) begin
			res_q <= res_d;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	`KST_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(SLOTS), "count above slots")
	`KST_ASSERT(a_no_write_in_sweep, clk, arst_n, rd_en |-> !wr_en, "write during sweep")
	`KST_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready, "busy")
	`KST_ASSERT_NEXT(a_ins_count, clk, arst_n, ins_commit, count_q == $past(count_inc), "count")

endmodule
